// ===== src/rrts_pkg.sv =====
// Shared types, codes and helpers for the round-robin time-slice scheduler.
// Used by the controller, datapath and top level under src; depends on nothing.
`timescale 1ns / 1ps

package rrts_pkg;

   // default sizing, used as the defaults of the top-level and datapath parameters
   localparam int RING_DEPTH_DEF = 64;
   localparam int TIME_BITS_DEF  = 16;

   localparam int LIMIT_W = 7;
   localparam int ID_W    = 8;
   localparam int FTIME_W = 16;

   // command codes
   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_SLICE  = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   // placement codes
   localparam logic [1:0] PL_RING    = 2'd0;
   localparam logic [1:0] PL_WAIT    = 2'd1;
   localparam logic [1:0] PL_NOT_ADD = 2'd2;

   // event kinds
   localparam logic [1:0] EV_NONE   = 2'd0;
   localparam logic [1:0] EV_SLICE  = 2'd1;
   localparam logic [1:0] EV_FINISH = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_ACTIVE_LIMIT = 2'd0;
   localparam logic [1:0] CSR_TIME_SLICE   = 2'd1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
   localparam int                 SLICE_RESET = 16;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [ID_W-1:0]    job_id;
      logic [FTIME_W-1:0] job_time;
   } req_type;

   typedef struct packed {
      logic [1:0]         placement;
      logic [1:0]         event_kind;
      logic [ID_W-1:0]    event_job;
      logic [FTIME_W-1:0] event_delay;
      logic               error;
   } rsp_type;

   localparam rsp_type RSP_QUIET = '{
      placement:   PL_NOT_ADD,
      event_kind:  EV_NONE,
      event_job:   '0,
      event_delay: '0,
      error:       1'b0
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_NEXT,
      ST_OUT
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic resolve;
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic need_next;
   } status_type;

   // next event for a head job with remaining time t
   function automatic rsp_type make_event(logic [1:0] placement, logic [ID_W-1:0] id,
                                          logic [31:0] t, logic [31:0] slice);
      rsp_type r;
      r.placement = placement;
      r.event_job = id;
      r.error     = 1'b0;
      if (t > slice) begin
         r.event_kind  = EV_SLICE;
         r.event_delay = slice[FTIME_W-1:0];
      end else begin
         r.event_kind  = EV_FINISH;
         r.event_delay = t[FTIME_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== src/rrts_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module rrts_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/rrts_ctrl.sv =====
// Controller state machine of the scheduler: sequences one command at a time.
// Depends on rrts_pkg.
`timescale 1ns / 1ps

module rrts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  rrts_pkg::status_type status,
   output rrts_pkg::ctrl_type   ctrl
);

   rrts_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rrts_pkg::ST_IDLE: begin
            if (req_valid) state_in = rrts_pkg::ST_EXEC;
         end
         rrts_pkg::ST_EXEC: begin
            state_in = status.need_next ? rrts_pkg::ST_NEXT : rrts_pkg::ST_OUT;
         end
         rrts_pkg::ST_NEXT: begin
            state_in = rrts_pkg::ST_OUT;
         end
         rrts_pkg::ST_OUT: begin
            if (!rsp_stall) state_in = rrts_pkg::ST_IDLE;
         end
         default: state_in = rrts_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = 1'b1;
      rsp_valid    = 1'b0;
      ctrl.capture = 1'b0;
      ctrl.exec    = 1'b0;
      ctrl.resolve = 1'b0;
      unique case (state_ff)
         rrts_pkg::ST_IDLE: begin
            req_stall    = 1'b0;
            ctrl.capture = req_valid;
         end
         rrts_pkg::ST_EXEC: ctrl.exec    = 1'b1;
         rrts_pkg::ST_NEXT: ctrl.resolve = 1'b1;
         rrts_pkg::ST_OUT:  rsp_valid    = 1'b1;
         default: ;
      endcase
   end

endmodule

// ===== src/rrts_dpath.sv =====
// Datapath of the scheduler: ring memory, head and count, config registers, result.
// Depends on rrts_pkg and rrts_ram.
`timescale 1ns / 1ps

module rrts_dpath #(
   parameter int RING_DEPTH = rrts_pkg::RING_DEPTH_DEF,
   parameter int TIME_BITS  = rrts_pkg::TIME_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rrts_pkg::ctrl_type         ctrl,
   output rrts_pkg::status_type       status,
   input  rrts_pkg::req_type          req_data,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [15:0]                csr_data,
   output rrts_pkg::rsp_type          rsp_data
);

   localparam int PTR_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W   = $clog2(RING_DEPTH + 1);
   localparam int SUM_W   = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
   localparam int CMP_W   = (CNT_W > rrts_pkg::LIMIT_W) ? CNT_W : rrts_pkg::LIMIT_W;
   localparam int ENTRY_W = rrts_pkg::ID_W + TIME_BITS;

   // captured command
   logic [1:0]               cmd_ff, cmd_in;
   logic [rrts_pkg::ID_W-1:0] id_ff, id_in;
   logic [TIME_BITS-1:0]     time_ff, time_in;

   logic [PTR_W-1:0]         head_ff, head_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [rrts_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic [TIME_BITS-1:0]     slice_ff, slice_in;
   rrts_pkg::rsp_type        result_ff, result_in;

   logic                     wr_en;
   logic [PTR_W-1:0]         wr_addr;
   logic [ENTRY_W-1:0]       wr_data;
   logic [PTR_W-1:0]         rd_addr;
   logic [ENTRY_W-1:0]       rd_data;

   logic [rrts_pkg::ID_W-1:0] rd_id;
   logic [TIME_BITS-1:0]     rd_time;
   logic [TIME_BITS-1:0]     charged_time;
   logic [PTR_W-1:0]         head_inc;
   logic [SUM_W-1:0]         tail_sum;
   logic [PTR_W-1:0]         tail;
   logic                     count_zero;
   logic                     count_one;
   logic                     room;

   rrts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_id   = rd_data[ENTRY_W-1:TIME_BITS];
   assign rd_time = rd_data[TIME_BITS-1:0];

   assign head_inc = (head_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
   assign tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail     = (tail_sum >= SUM_W'(RING_DEPTH)) ? PTR_W'(tail_sum - SUM_W'(RING_DEPTH))
                                                      : PTR_W'(tail_sum);

   assign count_zero = (count_ff == '0);
   assign count_one  = (count_ff == CNT_W'(1));
   assign room       = (CMP_W'(count_ff) < CMP_W'(limit_ff)) &&
                       (count_ff < CNT_W'(RING_DEPTH));

   // slice charge saturates at zero
   assign charged_time = (rd_time > slice_ff) ? rd_time - slice_ff : '0;

   // head is read while idle; the entry after it is read during execute
   assign rd_addr = ctrl.exec ? head_inc : head_ff;

   always_comb begin
      status.need_next = 1'b0;
      if (!count_zero && !count_one) begin
         if (cmd_ff == rrts_pkg::CMD_SLICE) begin
            status.need_next = 1'b1;
         end else if (cmd_ff == rrts_pkg::CMD_FINISH && rd_id == id_ff) begin
            status.need_next = 1'b1;
         end
      end
   end

   always_comb begin
      cmd_in  = cmd_ff;
      id_in   = id_ff;
      time_in = time_ff;
      if (ctrl.capture) begin
         cmd_in  = req_data.cmd;
         id_in   = req_data.job_id;
         time_in = TIME_BITS'(req_data.job_time);
      end
   end

   always_comb begin
      limit_in = limit_ff;
      slice_in = slice_ff;
      if (csr_we) begin
         unique case (csr_index)
            rrts_pkg::CSR_ACTIVE_LIMIT: limit_in = csr_data[rrts_pkg::LIMIT_W-1:0];
            rrts_pkg::CSR_TIME_SLICE:   slice_in = TIME_BITS'(csr_data);
            default: ;
         endcase
      end
   end

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      result_in = result_ff;
      wr_en     = 1'b0;
      wr_addr   = tail;
      wr_data   = {id_ff, time_ff};
      if (ctrl.exec) begin
         result_in = rrts_pkg::RSP_QUIET;
         unique case (cmd_ff)
            rrts_pkg::CMD_ADD: begin
               if (room) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  result_in.placement = rrts_pkg::PL_RING;
                  if (count_zero) begin
                     result_in = rrts_pkg::make_event(rrts_pkg::PL_RING, id_ff,
                                                      32'(time_ff), 32'(slice_ff));
                  end
               end else begin
                  result_in.placement = rrts_pkg::PL_WAIT;
               end
            end
            rrts_pkg::CMD_SLICE: begin
               if (count_zero) begin
                  result_in.error = 1'b1;
               end else begin
                  // on a full ring the tail is the head itself
                  wr_en   = 1'b1;
                  wr_data = {rd_id, charged_time};
                  head_in = head_inc;
                  if (count_one) begin
                     result_in = rrts_pkg::make_event(rrts_pkg::PL_NOT_ADD, rd_id,
                                                      32'(charged_time), 32'(slice_ff));
                  end
               end
            end
            rrts_pkg::CMD_FINISH: begin
               if (count_zero || rd_id != id_ff) begin
                  result_in.error = 1'b1;
               end else begin
                  head_in  = head_inc;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            default: ;
         endcase
      end else if (ctrl.resolve) begin
         result_in = rrts_pkg::make_event(result_ff.placement, rd_id,
                                          32'(rd_time), 32'(slice_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         limit_ff <= rrts_pkg::LIMIT_RESET;
         slice_ff <= TIME_BITS'(rrts_pkg::SLICE_RESET);
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         limit_ff <= limit_in;
         slice_ff <= slice_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      id_ff     <= id_in;
      time_ff   <= time_in;
      result_ff <= result_in;
   end

   assign rsp_data = result_ff;

endmodule

// ===== src/round_robin_time_slice_scheduler.sv =====
// Round-robin time-slice scheduler: top level joining controller and datapath.
// Depends on rrts_pkg, rrts_ctrl, rrts_dpath (and rrts_ram below it).
`timescale 1ns / 1ps

// One command is handled at a time. An accepted command passes the execute state,
// then, when the job that becomes the new head must be read back from the ring
// memory (a slice expiry or a finish with more than one job in the ring), a
// resolve state, before its result is offered. No new command is taken until the
// result transfer; the input is open again the next cycle. The resolve state comes
// from the ring memory: one registered read of the head, then one of the next head.
// Configuration writes are always ready and must be issued while the block is
// idle. The ring needs no clearing after reset.
module round_robin_time_slice_scheduler #(
   parameter int RING_DEPTH = rrts_pkg::RING_DEPTH_DEF,
   parameter int TIME_BITS  = rrts_pkg::TIME_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rrts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rrts_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);

   rrts_pkg::ctrl_type   ctrl;
   rrts_pkg::status_type status;

   assign csr_ready = 1'b1;

   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .ctrl      (ctrl)
   );

   rrts_dpath #(
      .RING_DEPTH (RING_DEPTH),
      .TIME_BITS  (TIME_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .status    (status),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // an accepted command is executed in the very next cycle
   a_capture_then_exec: assert property (@(posedge clock) disable iff (reset)
      ctrl.capture |=> ctrl.exec)
      else $error("accepted command not executed next cycle");

   // no new command while a result is pending
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall && !ctrl.exec && !ctrl.resolve)
      else $error("command work overlaps a pending result");

   // a result with no event carries zero job and delay
   a_quiet_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_kind == rrts_pkg::EV_NONE
         |-> rsp_data.event_job == '0 && rsp_data.event_delay == '0)
      else $error("eventless result carries job or delay");
`endif

endmodule

// ===== sim/tb_round_robin_time_slice_scheduler.sv =====
// Self-checking testbench for round_robin_time_slice_scheduler: directed and random commands,
// predicted by a ring model kept in the bench and checked field by field on every result.
// Depends on rrts_pkg and the scheduler RTL under src.
`timescale 1ns / 1ps

module tb_round_robin_time_slice_scheduler;
   import rrts_pkg::*;

   localparam int          RING_SLOTS  = 64;
   localparam int          STALL_LIMIT = 3000;
   localparam logic [1:0]  CMD_UNUSED  = 2'd3;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data  = '0;

   round_robin_time_slice_scheduler DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // scheduler state as the bench sees it
   logic [7:0]  ring_id   [RING_SLOTS];
   logic [15:0] ring_time [RING_SLOTS];
   logic [5:0]  head_slot = '0;
   int unsigned jobs_held = 0;
   int unsigned cur_limit = 64;
   logic [15:0] cur_slice = 16'd16;

   rsp_type     pending_events [$];
   int unsigned failures        = 0;
   int unsigned cmds_sent       = 0;
   int unsigned results_checked = 0;
   int unsigned csr_writes      = 0;
   int unsigned most_jobs       = 0;
   int unsigned send_idle_pct   = 16;
   int unsigned recv_idle_pct   = 84;
   int unsigned quiet_cycles    = 0;

   function automatic rsp_type with_head_event(rsp_type r);
      logic [15:0] rem;
      if (jobs_held == 0) return r;
      rem         = ring_time[head_slot];
      r.event_job = ring_id[head_slot];
      if (rem > cur_slice) begin
         r.event_kind  = EV_SLICE;
         r.event_delay = cur_slice;
      end else begin
         r.event_kind  = EV_FINISH;
         r.event_delay = rem;
      end
      return r;
   endfunction

   // applies one command to the bench ring and returns the result it must produce
   function automatic rsp_type schedule_cmd(req_type c);
      rsp_type     r;
      int unsigned lim;
      logic [5:0]  tail;
      r    = RSP_QUIET;
      lim  = (cur_limit < RING_SLOTS) ? cur_limit : RING_SLOTS;
      tail = 6'(head_slot + jobs_held);
      case (c.cmd)
         CMD_ADD: begin
            if (jobs_held < lim) begin
               ring_id[tail]   = c.job_id;
               ring_time[tail] = c.job_time;
               jobs_held++;
               r.placement = PL_RING;
               if (jobs_held == 1) r = with_head_event(r);
            end else begin
               r.placement = PL_WAIT;
            end
         end
         CMD_SLICE: begin
            if (jobs_held == 0) begin
               r.error = 1'b1;
            end else begin
               ring_time[head_slot] = (ring_time[head_slot] > cur_slice) ?
                                      ring_time[head_slot] - cur_slice : 16'd0;
               // a full ring rotates by moving the head pointer alone
               if (jobs_held < RING_SLOTS) begin
                  ring_id[tail]   = ring_id[head_slot];
                  ring_time[tail] = ring_time[head_slot];
               end
               head_slot++;
               r = with_head_event(r);
            end
         end
         CMD_FINISH: begin
            if (jobs_held == 0 || ring_id[head_slot] != c.job_id) begin
               r.error = 1'b1;
            end else begin
               head_slot++;
               jobs_held--;
               r = with_head_event(r);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic req_type make_req(logic [1:0] cmd, logic [7:0] id, logic [15:0] t);
      req_type c;
      c.cmd      = cmd;
      c.job_id   = id;
      c.job_time = t;
      return c;
   endfunction

   function automatic logic [15:0] random_time();
      case ($urandom_range(9))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom);
         default: return 16'($urandom_range(0, 64));
      endcase
   endfunction

   // mostly well-formed traffic: adds, rotations and finishes of the current head
   function automatic req_type random_cmd();
      int unsigned pick;
      req_type     c;
      pick = $urandom_range(99);
      c    = make_req(CMD_ADD, 8'($urandom), random_time());
      if (pick < 6)
         c.cmd = CMD_UNUSED;
      else if (jobs_held == 0)
         c.cmd = (pick < 90) ? CMD_ADD : (pick[0] ? CMD_SLICE : CMD_FINISH);
      else if (pick < 45)
         c.cmd = CMD_ADD;
      else if (pick < 75)
         c.cmd = CMD_SLICE;
      else begin
         c.cmd = CMD_FINISH;
         if (pick < 95) c.job_id = ring_id[head_slot];
      end
      return c;
   endfunction

   function automatic logic [15:0] random_limit();
      logic [6:0] lim;
      case ($urandom_range(7))
         0:       lim = 7'd0;
         1:       lim = 7'd1;
         2:       lim = 7'd2;
         3:       lim = 7'd64;
         4:       lim = 7'd127;
         default: lim = 7'($urandom_range(1, 64));
      endcase
      // upper bits of the write are don't-care for the limit
      return {9'($urandom), lim};
   endfunction

   function automatic logic [15:0] random_slice();
      case ($urandom_range(7))
         0:       return 16'd0;
         1:       return 16'd1;
         2:       return 16'hFFFF;
         3:       return 16'd16;
         4:       return 16'($urandom);
         default: return 16'($urandom_range(1, 300));
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_cmd(input req_type c);
      int unsigned gap;
      rsp_type     expect_rsp;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expect_rsp = schedule_cmd(c);
      pending_events.insert(pending_events.size(), expect_rsp);
      cmds_sent++;
      if (jobs_held > most_jobs) most_jobs = jobs_held;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_events.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_ACTIVE_LIMIT) cur_limit = 32'(val[6:0]);
      else cur_slice = val;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [15:0] limit, input logic [15:0] slice);
      drain_results();
      write_csr(CSR_ACTIVE_LIMIT, limit);
      write_csr(CSR_TIME_SLICE, slice);
   endtask

   // reset defaults: empty-ring errors, unused command, short first job, saturation
   task automatic test_basic_cmds();
      send_cmd(make_req(CMD_SLICE, 8'h00, 16'h0000));
      send_cmd(make_req(CMD_FINISH, 8'hFF, 16'hFFFF));
      send_cmd(make_req(CMD_UNUSED, 8'hFF, 16'hFFFF));
      send_cmd(make_req(CMD_ADD, 8'h00, 16'h0000));
      send_cmd(make_req(CMD_ADD, 8'hFF, 16'hFFFF));
      send_cmd(make_req(CMD_ADD, 8'hA5, 16'd16));
      send_cmd(make_req(CMD_SLICE, 8'h5A, 16'h5A5A));
      send_cmd(make_req(CMD_FINISH, 8'h00, 16'h0000));
      send_cmd(make_req(CMD_UNUSED, 8'h00, 16'h0000));
      send_cmd(make_req(CMD_SLICE, 8'h00, 16'h0000));
      send_cmd(make_req(CMD_FINISH, 8'hA5, 16'h0000));
      send_cmd(make_req(CMD_FINISH, 8'h00, 16'h0000));
      send_cmd(make_req(CMD_FINISH, 8'hFF, 16'h0000));
   endtask

   // limit of one and zero, zero and full-scale time slice
   task automatic test_config_extremes();
      set_config(16'd1, 16'd16);
      send_cmd(make_req(CMD_ADD, 8'h01, 16'd40));
      send_cmd(make_req(CMD_ADD, 8'h02, 16'd5));
      send_cmd(make_req(CMD_SLICE, 8'h00, 16'd0));
      send_cmd(make_req(CMD_FINISH, 8'h01, 16'd0));
      set_config(16'd0, 16'd0);
      send_cmd(make_req(CMD_ADD, 8'h03, 16'd5));
      send_cmd(make_req(CMD_SLICE, 8'h00, 16'd0));
      set_config(16'd64, 16'd0);
      send_cmd(make_req(CMD_ADD, 8'h07, 16'd5));
      send_cmd(make_req(CMD_SLICE, 8'h00, 16'd0));
      send_cmd(make_req(CMD_FINISH, 8'h07, 16'd0));
      set_config(16'd64, 16'hFFFF);
      send_cmd(make_req(CMD_ADD, 8'h09, 16'hFFFF));
      send_cmd(make_req(CMD_ADD, 8'h0A, 16'h0000));
      send_cmd(make_req(CMD_SLICE, 8'h00, 16'd0));
      send_cmd(make_req(CMD_FINISH, 8'h0A, 16'd0));
      send_cmd(make_req(CMD_FINISH, 8'h09, 16'd0));
   endtask

   // limit above the ring size: fill every slot, overflow, rotate with wrap, empty it
   task automatic test_full_ring();
      set_config({9'h1FF, 7'd127}, 16'd3);
      for (int i = 0; i <= RING_SLOTS; i++)
         send_cmd(make_req(CMD_ADD, 8'(i * 3), random_time()));
      for (int i = 0; i < 70; i++)
         send_cmd(make_req(CMD_SLICE, 8'($urandom), 16'($urandom)));
      send_cmd(make_req(CMD_FINISH, ~ring_id[head_slot], 16'd0));
      while (jobs_held != 0)
         send_cmd(make_req(CMD_FINISH, ring_id[head_slot], 16'($urandom)));
   endtask

   task automatic test_random_traffic(input int unsigned send_pct,
                                      input int unsigned recv_pct,
                                      input int unsigned count);
      int unsigned sent;
      int unsigned burst;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < count) begin
         // each new setting first waits for every outstanding result
         set_config(random_limit(), random_slice());
         burst = $urandom_range(20, 60);
         for (int k = 0; k < burst && sent < count; k++) begin
            send_cmd(random_cmd());
            sent++;
         end
      end
   endtask

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            $error("result transfer with no command outstanding: %h", rsp_data);
            failures++;
         end else begin
            want = pending_events.pop_front();
            check_field("placement", 32'(want.placement), 32'(rsp_data.placement));
            check_field("event_kind", 32'(want.event_kind), 32'(rsp_data.event_kind));
            check_field("event_job", 32'(want.event_job), 32'(rsp_data.event_job));
            check_field("event_delay", 32'(want.event_delay), 32'(rsp_data.event_delay));
            check_field("error", 32'(want.error), 32'(rsp_data.error));
         end
         results_checked++;
      end
   end

   // watchdog: too long without any transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_basic_cmds();
      test_config_extremes();
      test_full_ring();
      test_random_traffic(16, 84, 210);
      test_random_traffic(84, 16, 210);
      test_random_traffic(0, 0, 210);
      drain_results();
      repeat (8) @(posedge clock);
      if (pending_events.size() != 0) begin
         $error("%0d results never arrived", pending_events.size());
         failures++;
      end
      $display("summary: %0d commands sent, %0d results checked, %0d register writes",
               cmds_sent, results_checked, csr_writes);
      $display("summary: ring held up to %0d jobs across limit and slice settings",
               most_jobs);
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== sim.f =====
src/rrts_pkg.sv
src/rrts_ram.sv
src/rrts_ctrl.sv
src/rrts_dpath.sv
src/round_robin_time_slice_scheduler.sv
sim/tb_round_robin_time_slice_scheduler.sv
